// File: rtl/svia_pkg.sv
// ----------------------------------------------------------------------------
// svia_pkg: shared types and constants for the vector integer ALU
// Holds the operation codes, the lane geometry and the shuffle constants.
// ----------------------------------------------------------------------------
package svia_pkg;

  localparam int unsigned OpW    = 5;
  localparam int unsigned ImmW   = 10;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned VecW   = 2 * HalfW;
  localparam int unsigned WordW  = 32;
  localparam int unsigned Lanes  = VecW / WordW;
  localparam int unsigned Bytes  = VecW / 8;

  // Shuffle fill bytes for the constant control codes
  localparam logic [7:0] ShufZero = 8'h00;
  localparam logic [7:0] ShufOnes = 8'hFF;
  localparam logic [7:0] ShufMsb  = 8'h80;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 5'd0,
    OP_ADDI   = 5'd1,
    OP_SF     = 5'd2,
    OP_SFI    = 5'd3,
    OP_ADDH   = 5'd4,
    OP_SFH    = 5'd5,
    OP_AND    = 5'd6,
    OP_OR     = 5'd7,
    OP_XOR    = 5'd8,
    OP_NAND   = 5'd9,
    OP_NOR    = 5'd10,
    OP_ANDC   = 5'd11,
    OP_ORC    = 5'd12,
    OP_CGT    = 5'd13,
    OP_CLGT   = 5'd14,
    OP_CEQ    = 5'd15,
    OP_SHL    = 5'd16,
    OP_SHLI   = 5'd17,
    OP_ROT    = 5'd18,
    OP_ROTM   = 5'd19,
    OP_ROTMA  = 5'd20,
    OP_SELB   = 5'd21,
    OP_SHUFB  = 5'd22
  } op_t;

endpackage

// File: rtl/svia_lane.sv
// ----------------------------------------------------------------------------
// svia_lane: one 32-bit word lane
// Word, halfword, bitwise, compare, shift and select work on one word slice.
// ----------------------------------------------------------------------------
module svia_lane (
  input  svia_pkg::op_t                   op,
  input  logic [svia_pkg::WordW-1:0]      imm_w,
  input  logic [svia_pkg::WordW-1:0]      x,
  input  logic [svia_pkg::WordW-1:0]      y,
  input  logic [svia_pkg::WordW-1:0]      z,
  output logic [svia_pkg::WordW-1:0]      w
);

  logic [5:0]                   shl_n;
  logic [5:0]                   rtm_n;
  logic [2*svia_pkg::WordW-1:0] rot_x;
  logic [15:0]                  h_hi;
  logic [15:0]                  h_lo;

  assign shl_n = (op == svia_pkg::OP_SHLI) ? imm_w[5:0] : y[5:0];
  // rotate-and-mask counts are the negated operand, modulo 64
  assign rtm_n = 6'(~y[5:0] + 6'd1);
  assign rot_x = {x, x} << y[4:0];

  always_comb begin
    if (op == svia_pkg::OP_SFH) begin
      h_hi = y[31:16] - x[31:16];
      h_lo = y[15:0]  - x[15:0];
    end else begin
      h_hi = x[31:16] + y[31:16];
      h_lo = x[15:0]  + y[15:0];
    end
  end

  always_comb begin
    case (op)
      svia_pkg::OP_ADD:   w = x + y;
      svia_pkg::OP_ADDI:  w = x + imm_w;
      svia_pkg::OP_SF:    w = y - x;
      svia_pkg::OP_SFI:   w = imm_w - x;
      svia_pkg::OP_ADDH,
      svia_pkg::OP_SFH:   w = {h_hi, h_lo};
      svia_pkg::OP_AND:   w = x & y;
      svia_pkg::OP_OR:    w = x | y;
      svia_pkg::OP_XOR:   w = x ^ y;
      svia_pkg::OP_NAND:  w = ~(x & y);
      svia_pkg::OP_NOR:   w = ~(x | y);
      svia_pkg::OP_ANDC:  w = x & ~y;
      svia_pkg::OP_ORC:   w = x | ~y;
      svia_pkg::OP_CGT:   w = {svia_pkg::WordW{$signed(x) > $signed(y)}};
      svia_pkg::OP_CLGT:  w = {svia_pkg::WordW{x > y}};
      svia_pkg::OP_CEQ:   w = {svia_pkg::WordW{x == y}};
      svia_pkg::OP_SHL,
      svia_pkg::OP_SHLI:  w = shl_n[5] ? '0 : (x << shl_n[4:0]);
      svia_pkg::OP_ROT:   w = rot_x[2*svia_pkg::WordW-1:svia_pkg::WordW];
      svia_pkg::OP_ROTM:  w = rtm_n[5] ? '0 : (x >> rtm_n[4:0]);
      svia_pkg::OP_ROTMA: w = rtm_n[5] ? {svia_pkg::WordW{x[31]}}
                                       : 32'($signed(x) >>> rtm_n[4:0]);
      svia_pkg::OP_SELB:  w = (x & ~z) | (y & z);
      default:            w = '0;
    endcase
  end

endmodule

// File: rtl/svia_shuf.sv
// ----------------------------------------------------------------------------
// svia_shuf: byte shuffle
// Picks each result byte from the 32-byte string A:B or a constant fill.
// ----------------------------------------------------------------------------
module svia_shuf (
  input  logic [svia_pkg::VecW-1:0] a,
  input  logic [svia_pkg::VecW-1:0] b,
  input  logic [svia_pkg::VecW-1:0] c,
  output logic [svia_pkg::VecW-1:0] r
);

  // byte 0 is the most significant byte of A, byte 16 that of B
  logic [7:0] src [2*svia_pkg::Bytes];

  for (genvar j = 0; j < svia_pkg::Bytes; j++) begin : g_src
    assign src[j]                  = a[svia_pkg::VecW-1-8*j -: 8];
    assign src[j+svia_pkg::Bytes]  = b[svia_pkg::VecW-1-8*j -: 8];
  end

  for (genvar k = 0; k < svia_pkg::Bytes; k++) begin : g_byte
    logic [7:0] ctl;
    assign ctl = c[svia_pkg::VecW-1-8*k -: 8];
    always_comb begin
      if (!ctl[7])
        r[svia_pkg::VecW-1-8*k -: 8] = src[ctl[4:0]];
      else if (ctl[6] && ctl[5])
        r[svia_pkg::VecW-1-8*k -: 8] = svia_pkg::ShufMsb;
      else if (ctl[6])
        r[svia_pkg::VecW-1-8*k -: 8] = svia_pkg::ShufOnes;
      else
        r[svia_pkg::VecW-1-8*k -: 8] = svia_pkg::ShufZero;
    end
  end

endmodule

// File: rtl/simd_vector_integer_alu.sv
// ----------------------------------------------------------------------------
// simd_vector_integer_alu: 128-bit SIMD integer ALU
// Four word lanes and a byte shuffler work in parallel; a merge stage picks
// the result, which goes to an output register backed by a skid stage.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | op, imm, a_hi..c_lo
//   out_    | output    | out_valid/out_stall| r_hi, r_lo
//
// Flow: an item is computed in the cycle it transfers in and is registered in
//   the output register, or in the skid stage first if the output is stalled.
// One item per cycle while out_stall is low; the lane/shuffle merge feeds the output register.
// Reset (rst_n low, synchronous) empties the output register and skid stage.
// Stalls: one item is held in the skid stage while out_stall is high; in_stall
//   rises only when that skid stage is full.
// ----------------------------------------------------------------------------
module simd_vector_integer_alu (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [svia_pkg::OpW-1:0]        in_op,
  input  logic signed [svia_pkg::ImmW-1:0] in_imm,
  input  logic [svia_pkg::HalfW-1:0]      in_a_hi,
  input  logic [svia_pkg::HalfW-1:0]      in_a_lo,
  input  logic [svia_pkg::HalfW-1:0]      in_b_hi,
  input  logic [svia_pkg::HalfW-1:0]      in_b_lo,
  input  logic [svia_pkg::HalfW-1:0]      in_c_hi,
  input  logic [svia_pkg::HalfW-1:0]      in_c_lo,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [svia_pkg::HalfW-1:0]      out_r_hi,
  output logic [svia_pkg::HalfW-1:0]      out_r_lo
);

  svia_pkg::op_t                  op;
  logic [svia_pkg::WordW-1:0]     imm_w;
  logic [svia_pkg::VecW-1:0]      vec_a;
  logic [svia_pkg::VecW-1:0]      vec_b;
  logic [svia_pkg::VecW-1:0]      vec_c;
  logic [svia_pkg::VecW-1:0]      lane_res;
  logic [svia_pkg::VecW-1:0]      shuf_res;
  logic [svia_pkg::VecW-1:0]      res;

  logic                           out_valid_r, out_valid_nxt;
  logic [svia_pkg::VecW-1:0]      out_data_r;
  logic                           skid_valid_r, skid_valid_nxt;
  logic [svia_pkg::VecW-1:0]      skid_data_r;
  logic                           in_xfer;
  logic                           out_free;

  assign op    = svia_pkg::op_t'(in_op);
  // sign-extend the immediate to a full word
  assign imm_w = 32'(in_imm);
  assign vec_a = {in_a_hi, in_a_lo};
  assign vec_b = {in_b_hi, in_b_lo};
  assign vec_c = {in_c_hi, in_c_lo};

  // word lanes: lane k holds bits 32k+31..32k of each operand
  for (genvar k = 0; k < svia_pkg::Lanes; k++) begin : g_lane
    svia_lane u_lane (
      .op    (op),
      .imm_w (imm_w),
      .x     (vec_a[k*svia_pkg::WordW +: svia_pkg::WordW]),
      .y     (vec_b[k*svia_pkg::WordW +: svia_pkg::WordW]),
      .z     (vec_c[k*svia_pkg::WordW +: svia_pkg::WordW]),
      .w     (lane_res[k*svia_pkg::WordW +: svia_pkg::WordW])
    );
  end

  svia_shuf u_shuf (
    .a (vec_a),
    .b (vec_b),
    .c (vec_c),
    .r (shuf_res)
  );

  // merge: shuffle crosses lanes, everything else comes from the lanes
  assign res = (op == svia_pkg::OP_SHUFB) ? shuf_res : lane_res;

  // stall input only while the skid stage holds a result
  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !skid_valid_r;
  // output register can take new data this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      // advance: skid drains first, otherwise take the new transfer
      out_valid_nxt  = skid_valid_r || in_xfer;
      skid_valid_nxt = 1'b0;
    end else if (in_xfer) begin
      // hold output, park the new result in the skid stage
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_xfer) begin
        out_data_r <= res;
      end
    end else if (in_xfer) begin
      skid_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_r_hi  = out_data_r[svia_pkg::VecW-1:svia_pkg::HalfW];
  assign out_r_lo  = out_data_r[svia_pkg::HalfW-1:0];

endmodule

// File: rtl/svia_checker.sv
// ----------------------------------------------------------------------------
// svia_checker: port-level checks for the vector integer ALU
// Watches the handshake and buffering behavior seen on the top-level ports.
// ----------------------------------------------------------------------------
module svia_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [svia_pkg::HalfW-1:0]       out_r_hi,
  input logic [svia_pkg::HalfW-1:0]       out_r_lo
);

  // output empties after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  // input is only stalled while a result is already waiting
  a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall without a pending result");

  // a transfer in with a free output shows up next cycle
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (!out_valid || !out_stall)) |=> out_valid)
    else $error("accepted item did not reach output");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_r_hi) && $stable(out_r_lo)))
    else $error("stalled result changed");

endmodule

bind simd_vector_integer_alu svia_checker u_svia_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_r_hi  (out_r_hi),
  .out_r_lo  (out_r_lo)
);
